// ----- design/lzrc_pkg.sv -----
// Shared types and constants for the LZ run chunk decompressor.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package lzrc_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int POS_W        = 17;
    localparam int REP_W        = 17;
    localparam int CMD_W        = 16;
    localparam int LEN_W        = 5;
    localparam int FILL_W       = WIN_AW + 1;

    localparam logic [7:0]       RAW_CHUNK_FLAG = 8'h80;
    localparam logic [LEN_W-1:0] MIN_MATCH      = LEN_W'(3);
    localparam logic [REP_W-1:0] RUN_BIAS       = REP_W'(16);

    // One cycle's worth of datapath commands from the controller.
    typedef struct packed {
        logic take_in;
        logic clr_bits;
        logic cmd_hi;
        logic cmd_lo;
        logic hold_code;
        logic run_hi;
        logic run_lo;
        logic token_done;
        logic emit_lit;
        logic emit_bad;
        logic copy_start;
        logic copy_rd;
        logic copy_wr;
        logic run_emit;
        logic fill_step;
        logic clear_chunk;
    } t_cmd;

    typedef struct packed {
        logic is_pass;
        logic bits_empty;
        logic cmd_msb;
        logic off_zero;
        logic off_bad;
        logic copy_last;
        logic fill_last;
        logic out_free;
        logic item_last;
    } t_status;

endpackage
`default_nettype wire

// ----- design/lzrc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
`default_nettype none
module lzrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- design/lzrc_ctrl.sv -----
// Controller: sequencer state and chunk parse phase, drives datapath commands.
// Depends on lzrc_pkg for the command and status structs.
`default_nettype none
module lzrc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire lzrc_pkg::t_status i_sts,
    output lzrc_pkg::t_cmd        o_cmd
);
    import lzrc_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_COPY_RD = 3'd2;
    localparam logic [2:0] S_COPY_WR = 3'd3;
    localparam logic [2:0] S_FILL    = 3'd4;

    localparam logic [2:0] PH_FLAG     = 3'd0;
    localparam logic [2:0] PH_TOKEN    = 3'd1;
    localparam logic [2:0] PH_CMD_LO   = 3'd2;
    localparam logic [2:0] PH_CODE_LO  = 3'd3;
    localparam logic [2:0] PH_RUN_HI   = 3'd4;
    localparam logic [2:0] PH_RUN_LO   = 3'd5;
    localparam logic [2:0] PH_RUN_BYTE = 3'd6;
    localparam logic [2:0] PH_PASS     = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_phase, n_phase;
    logic       w_done;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        n_phase = r_phase;
        w_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.take_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_phase)
                    PH_FLAG: begin
                        if (i_sts.is_pass) begin
                            n_phase = PH_PASS;
                        end else begin
                            w_cmd.clr_bits = 1'b1;
                            n_phase        = PH_TOKEN;
                        end
                        w_done = 1'b1;
                    end
                    PH_PASS: begin
                        if (i_sts.out_free) begin
                            w_cmd.emit_lit = 1'b1;
                            w_done         = 1'b1;
                        end
                    end
                    PH_TOKEN: begin
                        if (i_sts.bits_empty) begin
                            w_cmd.cmd_hi = 1'b1;
                            n_phase      = PH_CMD_LO;
                            w_done       = 1'b1;
                        end else if (i_sts.cmd_msb) begin
                            w_cmd.hold_code = 1'b1;
                            n_phase         = PH_CODE_LO;
                            w_done          = 1'b1;
                        end else if (i_sts.out_free) begin
                            w_cmd.emit_lit   = 1'b1;
                            w_cmd.token_done = 1'b1;
                            w_done           = 1'b1;
                        end
                    end
                    PH_CMD_LO: begin
                        w_cmd.cmd_lo = 1'b1;
                        n_phase      = PH_TOKEN;
                        w_done       = 1'b1;
                    end
                    PH_CODE_LO: begin
                        if (i_sts.off_zero) begin
                            n_phase = PH_RUN_HI;
                            w_done  = 1'b1;
                        end else if (i_sts.off_bad) begin
                            if (i_sts.out_free) begin
                                w_cmd.emit_bad   = 1'b1;
                                w_cmd.token_done = 1'b1;
                                n_phase          = PH_TOKEN;
                                w_done           = 1'b1;
                            end
                        end else begin
                            w_cmd.copy_start = 1'b1;
                            w_cmd.token_done = 1'b1;
                            n_phase          = PH_TOKEN;
                            n_state          = S_COPY_RD;
                        end
                    end
                    PH_RUN_HI: begin
                        w_cmd.run_hi = 1'b1;
                        n_phase      = PH_RUN_LO;
                        w_done       = 1'b1;
                    end
                    PH_RUN_LO: begin
                        w_cmd.run_lo = 1'b1;
                        n_phase      = PH_RUN_BYTE;
                        w_done       = 1'b1;
                    end
                    PH_RUN_BYTE: begin
                        if (i_sts.out_free) begin
                            w_cmd.run_emit   = 1'b1;
                            w_cmd.token_done = 1'b1;
                            n_phase          = PH_TOKEN;
                            n_state          = S_FILL;
                        end
                    end
                    default: begin
                        n_phase = PH_FLAG;
                        w_done  = 1'b1;
                    end
                endcase
            end
            S_COPY_RD: begin
                w_cmd.copy_rd = 1'b1;
                n_state       = S_COPY_WR;
            end
            S_COPY_WR: begin
                if (i_sts.out_free) begin
                    w_cmd.copy_wr = 1'b1;
                    if (i_sts.copy_last) begin
                        w_done = 1'b1;
                    end else begin
                        n_state = S_COPY_RD;
                    end
                end
            end
            S_FILL: begin
                w_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    w_done = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The chunk state is dropped only once the final byte's work is complete.
        if (w_done) begin
            n_state = S_IDLE;
            if (i_sts.item_last) begin
                w_cmd.clear_chunk = 1'b1;
                n_phase           = PH_FLAG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_FLAG;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = w_cmd;

endmodule
`default_nettype wire

// ----- design/lzrc_dp.sv -----
// Datapath: input byte holding, command word, position, copy and fill counters,
// history RAM and the output register. Depends on lzrc_pkg and lzrc_ram.
`default_nettype none
module lzrc_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [7:0]             i_code_byte,
    input  wire logic                   i_chunk_end,
    input  wire logic                   i_out_stall,
    input  wire lzrc_pkg::t_cmd         i_cmd,
    output lzrc_pkg::t_status           o_sts,
    output logic                        o_out_valid,
    output logic [7:0]                  o_out_byte,
    output logic [lzrc_pkg::REP_W-1:0]  o_repeat_count,
    output logic                        o_bad_offset,
    output logic                        o_last_of_item
);
    import lzrc_pkg::*;

    logic [7:0]        r_byte, n_byte;
    logic              r_last, n_last;
    logic [CMD_W-1:0]  r_cmd_bits, n_cmd_bits;
    logic [LEN_W-1:0]  r_bits_left, n_bits_left;
    logic [15:0]       r_held, n_held;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_wfull, n_wfull;
    logic [WIN_AW-1:0] r_off, n_off;
    logic [LEN_W-1:0]  r_copy_left, n_copy_left;
    logic [WIN_AW-1:0] r_fill_addr, n_fill_addr;
    logic [FILL_W-1:0] r_fill_left, n_fill_left;

    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte, n_out_byte;
    logic [REP_W-1:0]  r_out_rep, n_out_rep;
    logic              r_out_bad, n_out_bad;
    logic              r_out_last, n_out_last;

    logic [WIN_AW-1:0] w_off;
    logic [REP_W-1:0]  w_run_cnt;
    logic [REP_W-1:0]  w_adv;
    logic [POS_W:0]    w_new_pos;
    logic              w_out_free;
    logic              w_ram_we;
    logic [WIN_AW-1:0] w_ram_waddr;
    logic [7:0]        w_ram_wdata;
    logic [WIN_AW-1:0] w_ram_raddr;
    logic [7:0]        w_ram_rdata;

    assign w_off      = {r_held[7:0], r_byte[7:4]};
    assign w_run_cnt  = {1'b0, r_held} + RUN_BIAS;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = i_cmd.run_emit ? w_run_cnt : REP_W'(1);
    assign w_new_pos  = {1'b0, r_pos} + {1'b0, w_adv};

    assign w_ram_we    = i_cmd.emit_lit || i_cmd.copy_wr || i_cmd.fill_step;
    assign w_ram_waddr = i_cmd.fill_step ? r_fill_addr : r_pos[WIN_AW-1:0];
    assign w_ram_wdata = i_cmd.copy_wr ? w_ram_rdata : r_byte;
    // Copies read behind the write pointer; the window index wraps naturally.
    assign w_ram_raddr = r_pos[WIN_AW-1:0] - r_off;

    lzrc_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (i_cmd.copy_rd),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_byte      = r_byte;
        n_last      = r_last;
        n_cmd_bits  = r_cmd_bits;
        n_bits_left = r_bits_left;
        n_held      = r_held;
        n_pos       = r_pos;
        n_wfull     = r_wfull;
        n_off       = r_off;
        n_copy_left = r_copy_left;
        n_fill_addr = r_fill_addr;
        n_fill_left = r_fill_left;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_out_rep   = r_out_rep;
        n_out_bad   = r_out_bad;
        n_out_last  = r_out_last;

        if (i_cmd.take_in) begin
            n_byte = i_code_byte;
            n_last = i_chunk_end;
        end
        if (i_cmd.clr_bits) begin
            n_bits_left = '0;
        end
        if (i_cmd.cmd_hi) begin
            n_cmd_bits = {r_byte, 8'h00};
        end
        if (i_cmd.cmd_lo) begin
            n_cmd_bits  = r_cmd_bits | {8'h00, r_byte};
            n_bits_left = LEN_W'(CMD_W);
        end
        if (i_cmd.hold_code) begin
            n_held = {8'h00, r_byte};
        end
        if (i_cmd.run_hi) begin
            n_held = {r_byte, 8'h00};
        end
        if (i_cmd.run_lo) begin
            n_held = r_held | {8'h00, r_byte};
        end
        if (i_cmd.token_done) begin
            n_cmd_bits  = {r_cmd_bits[CMD_W-2:0], 1'b0};
            n_bits_left = r_bits_left - LEN_W'(1);
        end
        if (i_cmd.emit_lit || i_cmd.copy_wr || i_cmd.run_emit) begin
            n_pos   = w_new_pos[POS_W-1:0];
            n_wfull = r_wfull || (w_new_pos >= (POS_W+1)'(WINDOW_DEPTH));
        end
        if (i_cmd.emit_lit) begin
            n_out_valid = 1'b1;
            n_out_byte  = r_byte;
            n_out_rep   = REP_W'(1);
            n_out_bad   = 1'b0;
            n_out_last  = 1'b1;
        end
        if (i_cmd.emit_bad) begin
            n_out_valid = 1'b1;
            n_out_byte  = 8'h00;
            n_out_rep   = '0;
            n_out_bad   = 1'b1;
            n_out_last  = 1'b1;
        end
        if (i_cmd.copy_start) begin
            n_off       = w_off;
            n_copy_left = {1'b0, r_byte[3:0]} + MIN_MATCH;
        end
        if (i_cmd.copy_wr) begin
            n_out_valid = 1'b1;
            n_out_byte  = w_ram_rdata;
            n_out_rep   = REP_W'(1);
            n_out_bad   = 1'b0;
            n_out_last  = (r_copy_left == LEN_W'(1));
            n_copy_left = r_copy_left - LEN_W'(1);
        end
        if (i_cmd.run_emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = r_byte;
            n_out_rep   = w_run_cnt;
            n_out_bad   = 1'b0;
            n_out_last  = 1'b1;
            n_fill_addr = r_pos[WIN_AW-1:0];
            // A run of a full window or more overwrites every entry exactly once.
            if (w_run_cnt >= REP_W'(WINDOW_DEPTH)) begin
                n_fill_left = FILL_W'(WINDOW_DEPTH);
            end else begin
                n_fill_left = w_run_cnt[FILL_W-1:0];
            end
        end
        if (i_cmd.fill_step) begin
            n_fill_addr = r_fill_addr + WIN_AW'(1);
            n_fill_left = r_fill_left - FILL_W'(1);
        end
        if (i_cmd.clear_chunk) begin
            n_cmd_bits  = '0;
            n_bits_left = '0;
            n_held      = '0;
            n_pos       = '0;
            n_wfull     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= 1'b0;
            r_cmd_bits  <= '0;
            r_bits_left <= '0;
            r_held      <= '0;
            r_pos       <= '0;
            r_wfull     <= 1'b0;
            r_copy_left <= '0;
            r_fill_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_last      <= n_last;
            r_cmd_bits  <= n_cmd_bits;
            r_bits_left <= n_bits_left;
            r_held      <= n_held;
            r_pos       <= n_pos;
            r_wfull     <= n_wfull;
            r_copy_left <= n_copy_left;
            r_fill_left <= n_fill_left;
            r_out_valid <= n_out_valid;
        end
        r_byte      <= n_byte;
        r_off       <= n_off;
        r_fill_addr <= n_fill_addr;
        r_out_byte  <= n_out_byte;
        r_out_rep   <= n_out_rep;
        r_out_bad   <= n_out_bad;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        o_sts            = '0;
        o_sts.is_pass    = (r_byte == RAW_CHUNK_FLAG);
        o_sts.bits_empty = (r_bits_left == '0);
        o_sts.cmd_msb    = r_cmd_bits[CMD_W-1];
        o_sts.off_zero   = (w_off == '0);
        o_sts.off_bad    = !r_wfull && ({(POS_W-WIN_AW)'(0), w_off} > r_pos);
        o_sts.copy_last  = (r_copy_left == LEN_W'(1));
        o_sts.fill_last  = (r_fill_left == FILL_W'(1));
        o_sts.out_free   = w_out_free;
        o_sts.item_last  = r_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_repeat_count = r_out_rep;
    assign o_bad_offset   = r_out_bad;
    assign o_last_of_item = r_out_last;

endmodule
`default_nettype wire

// ----- design/lz_run_chunk_decompressor.sv -----
// LZ run chunk decompressor, 4096-byte window.
//
// Input channel: one compressed byte per request (i_code_byte), with
// i_chunk_end marking the last byte of a chunk. Output channel: one decoded
// result per request: a byte, its repeat count (more than one only for runs),
// a flag for a back offset that reaches before the chunk start, and a marker
// on the final result caused by each input byte.
// Decoding: an input byte is taken, then decoded in the next cycle. For a
// copy, each history byte needs a RAM read and then a write-back, since
// copies may overlap their own output. After the last byte of a run, the run
// is written into the history RAM one entry per cycle, up to the whole
// window. The first result of a request is registered from the decode step,
// or for a copy from its first write-back, which reads history first. The
// output register holds one result; while it is stalled, decoding waits and
// the input is stalled. Reset (synchronous, active low) returns the parser to
// expect a chunk flag; the history RAM is not cleared.
// Chunk state is cleared after the final byte of each chunk is decoded.
`default_nettype none
module lz_run_chunk_decompressor (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [7:0]                  i_code_byte,
    input  wire logic                        i_chunk_end,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [7:0]                  o_out_byte,
    output logic      [lzrc_pkg::REP_W-1:0]  o_repeat_count,
    output logic                             o_bad_offset,
    output logic                             o_last_of_item
);
    import lzrc_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    lzrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lzrc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_code_byte    (i_code_byte),
        .i_chunk_end    (i_chunk_end),
        .i_out_stall    (i_out_stall),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_repeat_count (o_repeat_count),
        .o_bad_offset   (o_bad_offset),
        .o_last_of_item (o_last_of_item)
    );

endmodule
`default_nettype wire

// ----- tb/lzrc_scoreboard_pkg.sv -----
// Scoreboard for the LZ run chunk decompressor: a byte-level decoder that predicts
// every result of an accepted request, and a checker for the results the block returns.
// Depends on lzrc_pkg for widths, the window depth and the copy-through flag.
package lzrc_scoreboard_pkg;

    import lzrc_pkg::*;

    typedef enum logic [3:0] {
        WAIT_FLAG,
        WAIT_TOKEN,
        WAIT_CMD_LO,
        WAIT_CODE_LO,
        WAIT_RUN_HI,
        WAIT_RUN_LO,
        WAIT_RUN_BYTE,
        PASS_BYTES
    } t_parse_state;

    typedef struct packed {
        logic [7:0]       data;
        logic [REP_W-1:0] reps;
        logic             bad;
        logic             last;
    } t_decoded;

    class lz_scoreboard;

        logic [7:0]       window [WINDOW_DEPTH];
        logic [POS_W-1:0] pos;
        logic [CMD_W-1:0] cmd_word;
        logic [4:0]       tokens_left;
        t_parse_state     state;
        logic [15:0]      held;
        bit               full;
        t_decoded         due [$];
        t_decoded         tail;
        bit               have_tail;
        int               mismatches;

        function new();
            mismatches = 0;
            have_tail  = 1'b0;
            clear_chunk();
        endfunction

        function void clear_chunk();
            pos         = '0;
            cmd_word    = '0;
            tokens_left = '0;
            state       = WAIT_FLAG;
            held        = '0;
            full        = 1'b0;
        endfunction

        function void advance(int n);
            int np;
            np = int'(pos) + n;
            if (np >= WINDOW_DEPTH) begin
                full = 1'b1;
            end
            pos = POS_W'(np);
        endfunction

        function void next_token();
            cmd_word    = cmd_word << 1;
            tokens_left = tokens_left - 5'd1;
            state       = WAIT_TOKEN;
        endfunction

        // The newest result is held back until the request is fully decoded,
        // so that the end-of-request marker can be set on it.
        function void emit(logic [7:0] data, logic [REP_W-1:0] reps, logic bad);
            if (have_tail) begin
                due.push_back(tail);
            end
            tail.data = data;
            tail.reps = reps;
            tail.bad  = bad;
            tail.last = 1'b0;
            have_tail = 1'b1;
        endfunction

        function void note_request(logic [7:0] b, logic chunk_last);
            logic [11:0]      off;
            logic [11:0]      src;
            logic [POS_W-1:0] p;
            logic [REP_W-1:0] cnt;
            int               len;
            case (state)
                WAIT_FLAG: begin
                    if (b == RAW_CHUNK_FLAG) begin
                        state = PASS_BYTES;
                    end else begin
                        tokens_left = '0;
                        state       = WAIT_TOKEN;
                    end
                end
                PASS_BYTES: begin
                    window[pos[11:0]] = b;
                    advance(1);
                    emit(b, REP_W'(1), 1'b0);
                end
                WAIT_TOKEN: begin
                    if (tokens_left == 5'd0) begin
                        cmd_word = {b, 8'h00};
                        state    = WAIT_CMD_LO;
                    end else if (cmd_word[CMD_W-1]) begin
                        held  = {8'h00, b};
                        state = WAIT_CODE_LO;
                    end else begin
                        window[pos[11:0]] = b;
                        advance(1);
                        emit(b, REP_W'(1), 1'b0);
                        next_token();
                    end
                end
                WAIT_CMD_LO: begin
                    cmd_word[7:0] = b;
                    tokens_left   = 5'd16;
                    state         = WAIT_TOKEN;
                end
                WAIT_CODE_LO: begin
                    off = {held[7:0], b[7:4]};
                    if (off == 12'd0) begin
                        state = WAIT_RUN_HI;
                    end else begin
                        // Until the window has filled once, an offset may not
                        // reach behind the first byte of the chunk.
                        if (!full && POS_W'(off) > pos) begin
                            emit(8'h00, '0, 1'b1);
                        end else begin
                            len = int'(b[3:0]) + 3;
                            for (int k = 0; k < len; k++) begin
                                p   = pos + POS_W'(k);
                                src = p[11:0] - off;
                                window[p[11:0]] = window[src];
                                emit(window[src], REP_W'(1), 1'b0);
                            end
                            advance(len);
                        end
                        next_token();
                    end
                end
                WAIT_RUN_HI: begin
                    held  = {b, 8'h00};
                    state = WAIT_RUN_LO;
                end
                WAIT_RUN_LO: begin
                    held[7:0] = b;
                    state     = WAIT_RUN_BYTE;
                end
                WAIT_RUN_BYTE: begin
                    cnt = REP_W'(held) + RUN_BIAS;
                    if (cnt >= REP_W'(WINDOW_DEPTH)) begin
                        foreach (window[i]) begin
                            window[i] = b;
                        end
                    end else begin
                        for (int k = 0; k < int'(cnt); k++) begin
                            p = pos + POS_W'(k);
                            window[p[11:0]] = b;
                        end
                    end
                    advance(int'(cnt));
                    emit(b, cnt, 1'b0);
                    next_token();
                end
                default: begin
                    state = WAIT_FLAG;
                end
            endcase
            if (have_tail) begin
                tail.last = 1'b1;
                due.push_back(tail);
                have_tail = 1'b0;
            end
            if (chunk_last) begin
                clear_chunk();
            end
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [7:0] data, logic [REP_W-1:0] reps, logic bad,
                          logic last);
            t_decoded want;
            if (due.size() == 0) begin
                report($sformatf("unexpected result byte %02h count %0d bad %0b last %0b",
                                 data, reps, bad, last));
                return;
            end
            want = due.pop_front();
            if (data !== want.data) begin
                report($sformatf("byte %02h, expected %02h", data, want.data));
            end
            if (reps !== want.reps) begin
                report($sformatf("repeat count %0d, expected %0d", reps, want.reps));
            end
            if (bad !== want.bad) begin
                report($sformatf("bad offset %0b, expected %0b", bad, want.bad));
            end
            if (last !== want.last) begin
                report($sformatf("last of item %0b, expected %0b", last, want.last));
            end
        endtask

    endclass

endpackage

// ----- tb/tb_top.sv -----
// Top level of the LZ run chunk decompressor test: clock, reset, request driver,
// result monitor and chunk generators. Depends on lzrc_pkg and lzrc_scoreboard_pkg.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lzrc_pkg::*;
    import lzrc_scoreboard_pkg::*;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic [7:0]       i_code_byte = 8'h00;
    logic             i_chunk_end = 1'b0;
    logic             i_out_stall = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [7:0]       o_out_byte;
    logic [REP_W-1:0] o_repeat_count;
    logic             o_bad_offset;
    logic             o_last_of_item;

    lz_scoreboard sb = new();

    logic [7:0] chunk_bytes [$];
    logic [7:0] token_bytes [$];
    int         gen_pos;
    bit         gen_full;
    int         idle_pct  = 0;
    int         stall_pct = 0;

    lz_run_chunk_decompressor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_code_byte    (i_code_byte),
        .i_chunk_end    (i_chunk_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_repeat_count (o_repeat_count),
        .o_bad_offset   (o_bad_offset),
        .o_last_of_item (o_last_of_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_byte, o_repeat_count, o_bad_offset, o_last_of_item);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid  <= 1'b0;
            i_code_byte <= 8'($urandom);
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_code_byte <= b;
        i_chunk_end <= last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_request(b, last);
    endtask

    task automatic send_chunk();
        for (int i = 0; i < chunk_bytes.size(); i++) begin
            send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
        end
        chunk_bytes.delete();
    endtask

    function automatic void gen_advance(int n);
        gen_pos += n;
        if (gen_pos >= WINDOW_DEPTH) begin
            gen_full = 1'b1;
        end
    endfunction

    // Appends one token to token_bytes and returns its command bit.
    function automatic bit add_token();
        int         pick;
        int         reach;
        int         near;
        int         off;
        int         cnt;
        logic [3:0] len;
        pick  = $urandom_range(99);
        reach = (gen_full || gen_pos > 4095) ? 4095 : gen_pos;
        len   = 4'($urandom);
        if (pick >= 45 && pick < 82 && reach > 0) begin
            // Short offsets can make the copy overlap its own output.
            near = (reach < 4) ? reach : 4;
            off  = $urandom_range(1) ? $urandom_range(reach, 1) : $urandom_range(near, 1);
            token_bytes.push_back(8'(off >> 4));
            token_bytes.push_back({4'(off), len});
            gen_advance(int'(len) + 3);
            return 1'b1;
        end
        if (pick >= 82 && pick < 90 && reach < 4095) begin
            off = $urandom_range(4095, reach + 1);
            token_bytes.push_back(8'(off >> 4));
            token_bytes.push_back({4'(off), len});
            return 1'b1;
        end
        if (pick >= 90) begin
            cnt = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(255);
            token_bytes.push_back(8'h00);
            token_bytes.push_back({4'h0, len});
            token_bytes.push_back(8'(cnt >> 8));
            token_bytes.push_back(8'(cnt));
            token_bytes.push_back(8'($urandom));
            gen_advance(cnt + 16);
            return 1'b1;
        end
        token_bytes.push_back(8'($urandom));
        gen_advance(1);
        return 1'b0;
    endfunction

    function automatic void add_group(int count);
        logic [15:0] bits;
        bits = 16'($urandom);
        token_bytes.delete();
        for (int i = 0; i < count; i++) begin
            bits[15-i] = add_token();
        end
        chunk_bytes.push_back(bits[15:8]);
        chunk_bytes.push_back(bits[7:0]);
        foreach (token_bytes[i]) begin
            chunk_bytes.push_back(token_bytes[i]);
        end
    endfunction

    function automatic void build_coded_chunk();
        logic [7:0] flag;
        int         ntok;
        int         keep;
        do begin
            flag = 8'($urandom);
        end while (flag == RAW_CHUNK_FLAG);
        chunk_bytes.push_back(flag);
        gen_pos  = 0;
        gen_full = 1'b0;
        ntok     = $urandom_range(30, 1);
        while (ntok > 0) begin
            add_group(ntok > 16 ? 16 : ntok);
            ntok -= 16;
        end
        // Some chunks are cut short, leaving a token or command word unfinished.
        if ($urandom_range(99) < 15) begin
            keep = $urandom_range(chunk_bytes.size() - 1, 1);
            while (chunk_bytes.size() > keep) begin
                void'(chunk_bytes.pop_back());
            end
        end
    endfunction

    function automatic void build_raw_chunk(logic [7:0] flag, int n);
        chunk_bytes.push_back(flag);
        for (int i = 0; i < n; i++) begin
            chunk_bytes.push_back(8'($urandom));
        end
    endfunction

    initial begin
        int random_sent;
        int pick;
        random_sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A chunk holding only its flag, then a short copy-through chunk.
        chunk_bytes = '{8'h7f};
        send_chunk();
        chunk_bytes = '{RAW_CHUNK_FLAG, 8'hff, 8'h00};
        send_chunk();
        // Literals, an overlapping copy, an offset before the chunk start, two
        // longest runs that wrap the position, then a copy from the far end.
        chunk_bytes = '{8'h00, 8'h3e, 8'h00, 8'ha5, 8'h5a, 8'h00, 8'h1f, 8'hff, 8'hff,
                        8'h00, 8'h00, 8'hff, 8'hff, 8'h00,
                        8'h00, 8'h0f, 8'hff, 8'hff, 8'hc3, 8'hff, 8'hf0};
        send_chunk();

        while (random_sent < 380) begin
            case ((random_sent / 95) % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 58;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 58;
                end
                default: begin
                    idle_pct  = 19;
                    stall_pct = 19;
                end
            endcase
            pick = $urandom_range(99);
            if (pick < 12) begin
                build_raw_chunk(RAW_CHUNK_FLAG, $urandom_range(30, 1));
            end else if (pick < 20) begin
                build_raw_chunk(8'($urandom), $urandom_range(24));
            end else begin
                build_coded_chunk();
            end
            random_sent += chunk_bytes.size();
            send_chunk();
        end
        i_in_valid <= 1'b0;

        while (sb.due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("lz_run_chunk_decompressor test passed");
        end else begin
            $display("lz_run_chunk_decompressor test failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("lz_run_chunk_decompressor test failed");
        $finish;
    end

endmodule

// ----- lz_run_chunk_decompressor.f -----
design/lzrc_pkg.sv
design/lzrc_ram.sv
design/lzrc_ctrl.sv
design/lzrc_dp.sv
design/lz_run_chunk_decompressor.sv
tb/lzrc_scoreboard_pkg.sv
tb/tb_top.sv
